// File: design/wwpc_pkg.sv
// shared types, constants and byte helpers for the whole-word pattern censor
// used by the censor top level, its cells and its output queue; depends on nothing
package wwpc_pkg;

	localparam int BYTE_W = 8;
	localparam int PAT_W  = 64;
	localparam int LEN_W  = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_CHAR = 2'd2;

	localparam logic [BYTE_W-1:0] REPL_RESET = 8'h2a;
	localparam logic [BYTE_W-1:0] CASE_GAP   = 8'd32;

	typedef logic [BYTE_W-1:0] byte_t;

	// per-cell controls for one cycle
	typedef struct packed {
		logic  emit;   // head leaves, window moves down one place
		logic  load;   // this cell takes the incoming byte
		logic  ovw;    // this cell takes the replacement while shifting
		byte_t repl;
	} cell_ctl_t;

	typedef struct packed {
		logic  last;
		byte_t data;
	} out_item_t;

	function automatic logic is_letter(input byte_t c);
		return (c inside {["a":"z"], ["A":"Z"]});
	endfunction

	function automatic byte_t fold(input byte_t c);
		if (c inside {["A":"Z"]})
			return c + CASE_GAP;
		return c;
	endfunction

endpackage

// File: design/whole_word_pattern_censor.sv
// top level of the whole-word pattern censor: config registers, window control
// depends on wwpc_pkg, wwpc_cell, wwpc_out_buf
//
// Text bytes enter on the slave stream and leave in order on the master stream,
// every byte of a case-insensitive, whole-word match of the configured pattern
// being replaced by replacement_char. The block takes one byte per cycle
// while the output queue has space and no flush is running; the head of a row
// of PATTERN_MAX+1 window cells is decided as each byte moves out, so once
// pattern_len bytes are held every input byte pushes one byte out. A byte with
// tlast flushes the window at one byte per cycle while the queue has space,
// holding s_axis_tready low until it is empty. Output beats pass a two-entry
// queue, so a stalled master side does not stop input at once.
// The window needs no clearing after reset. Configuration goes in between texts.
module whole_word_pattern_censor
	import wwpc_pkg::*;
#(
	parameter int PATTERN_MAX = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // in_byte
	input  logic                 s_axis_tlast,  // in_last
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // out_byte
	output logic                 m_axis_tlast   // out_last
);

	localparam int DEPTH = PATTERN_MAX + 1;
	localparam int CW    = $clog2(PATTERN_MAX + 2);
	localparam int IW    = $clog2(DEPTH);
	localparam logic [LEN_W-1:0] PMAX_LEN = LEN_W'(PATTERN_MAX);

	logic [PAT_W-1:0] pattern_q;
	logic [LEN_W-1:0] len_q;
	byte_t            repl_q;

	logic [CW-1:0] pend_q;
	logic [CW-1:0] skip_q;
	byte_t         before_q;
	logic          start_q;
	logic          flush_q;

	logic [CW-1:0] n;
	logic [CW-1:0] pend_eff;
	logic          accept, flush_eff, work_cur, work_eff, emit;
	logic          head_match, decide, before_ok, after_ok, replace, text_end;
	logic          space;
	out_item_t     item;

	cell_ctl_t ctl [DEPTH];
	byte_t     eff [DEPTH];
	byte_t     nbr [DEPTH];
	logic [DEPTH-1:0] hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			len_q     <= '0;
			repl_q    <= REPL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_BYTES:    pattern_q <= cfg_data;
				REG_PATTERN_LEN:      len_q     <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_CHAR: repl_q    <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// longer lengths saturate at PATTERN_MAX
	assign n = (len_q > PMAX_LEN) ? CW'(PATTERN_MAX) : CW'(len_q);

	assign work_cur = (pend_q != '0) && (flush_q || (pend_q > n));
	assign s_axis_tready = !work_cur && space;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign pend_eff  = pend_q + CW'(accept);
	assign flush_eff = flush_q || (accept && s_axis_tlast);
	assign work_eff  = (pend_eff != '0) && (flush_eff || (pend_eff > n));
	assign emit      = work_eff && space;

	always_comb begin
		head_match = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			head_match = head_match && (hit[i] || !(CW'(i) < n));
		end
	end

	assign decide    = emit && (skip_q == '0) && (n != '0) && (pend_eff >= n) && head_match;
	assign before_ok = start_q || !is_letter(before_q);
	assign after_ok  = (pend_eff == n) || !is_letter(eff[n[IW-1:0]]);
	assign replace   = decide && before_ok && after_ok;
	assign text_end  = emit && flush_eff && (pend_eff == CW'(1));

	assign item.data = replace ? repl_q : eff[0];
	assign item.last = text_end;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		byte_t pat_byte;

		if (i < PATTERN_MAX) begin : g_pat
			assign pat_byte = pattern_q[BYTE_W*i +: BYTE_W];
		end else begin : g_nopat
			assign pat_byte = '0;
		end

		if (i < DEPTH - 1) begin : g_nbr
			assign nbr[i] = eff[i+1];
		end else begin : g_end
			assign nbr[i] = '0;
		end

		assign ctl[i].emit = emit;
		assign ctl[i].load = accept && (pend_q == CW'(i));
		assign ctl[i].ovw  = replace && (CW'(i + 1) < n);
		assign ctl[i].repl = repl_q;

		wwpc_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.in_byte  (s_axis_tdata),
			.pat_byte (pat_byte),
			.nbr_eff  (nbr[i]),
			.eff      (eff[i]),
			.hit      (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			skip_q   <= '0;
			before_q <= '0;
			start_q  <= 1'b1;
			flush_q  <= 1'b0;
		end else begin
			pend_q <= pend_eff - CW'(emit);
			if (text_end) begin
				skip_q   <= '0;
				before_q <= '0;
				start_q  <= 1'b1;
				flush_q  <= 1'b0;
			end else begin
				flush_q <= flush_eff;
				if (decide) begin
					skip_q <= n - CW'(1);
				end else if (emit && (skip_q != '0)) begin
					skip_q <= skip_q - CW'(1);
				end
				if (emit) begin
					before_q <= item.data;
					start_q  <= 1'b0;
				end
			end
		end
	end

	wwpc_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (emit),
		.push_item     (item),
		.space         (space),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: design/wwpc_cell.sv
// one window cell: holds a pending text byte, hands it to its lower neighbor
// depends on wwpc_pkg
module wwpc_cell
	import wwpc_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  byte_t     in_byte,
	input  byte_t     pat_byte,
	input  byte_t     nbr_eff,
	output byte_t     eff,
	output logic      hit
);

	byte_t cell_q;

	// view of the window with the incoming byte already appended
	assign eff = ctl.load ? in_byte : cell_q;
	assign hit = (fold(eff) == fold(pat_byte));

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			cell_q <= ctl.ovw ? ctl.repl : nbr_eff;
		end else begin
			cell_q <= eff;
		end
	end

endmodule

// File: design/wwpc_out_buf.sv
// two-entry output queue between the window and the master stream side
// depends on wwpc_pkg
module wwpc_out_buf
	import wwpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      space,
	output logic      m_axis_tvalid,
	input  logic      m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic      m_axis_tlast    // out_last
);

	out_item_t mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	out_item_t  head;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign space         = (cnt_q != 2'd2);
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign head          = mem[rd_q];
	assign m_axis_tdata  = head.data;
	assign m_axis_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: design/wwpc_checker.sv
// port-level checks for the whole-word pattern censor, bound to its top level
// depends on whole_word_pattern_censor
module wwpc_checker #(
	parameter int PATTERN_MAX = 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 s_axis_tlast,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [7:0]           m_axis_tdata,
	input logic                 m_axis_tlast
);

	localparam int HELD_MAX = PATTERN_MAX + 3;
	localparam int HW = $clog2(HELD_MAX + 2);

	logic          in_beat, out_beat;
	logic [HW-1:0] held_q;
	logic [1:0]    open_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			open_q <= '0;
		end else begin
			held_q <= held_q + HW'(in_beat) - HW'(out_beat);
			open_q <= open_q + 2'(in_beat && s_axis_tlast) - 2'(out_beat && m_axis_tlast);
		end
	end

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// bytes inside the block never exceed the window plus the output queue
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(HELD_MAX))
		else $error("more bytes held than the window and queue can store");

	// an output last beat closes a text whose last input byte came earlier
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_axis_tlast |-> open_q != 2'd0)
		else $error("output last beat without an open text");

	// output stays quiet when no byte is held
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == '0 |-> !m_axis_tvalid)
		else $error("output beat offered with no byte held");

	// configuration writes are taken at once
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind whole_word_pattern_censor wwpc_checker #(.PATTERN_MAX(PATTERN_MAX)) u_wwpc_checker (.*);

// File: bench/censor_checker.sv
// stream checker for the whole-word pattern censor: predicts the censored text
// from the input and config beats it sees, and compares the output beats
// depends on wwpc_pkg for the register indexes and the output beat type
module censor_checker
	import wwpc_pkg::*;
#(
	parameter int PATTERN_MAX = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // in_byte
	input  logic                 s_axis_tlast,  // in_last
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,  // out_byte
	input  logic                 m_axis_tlast,  // out_last
	output int                   fail_count,
	output int                   owed_beats
);

	localparam int DEPTH    = PATTERN_MAX + 1;
	localparam int SHOW_MAX = 40;

	logic [PAT_W-1:0] pat_bytes;
	logic [LEN_W-1:0] pat_len;
	byte_t            repl_char;

	byte_t     window [DEPTH];
	int        held;
	int        skip;
	byte_t     prev_out;
	logic      text_start;
	byte_t     step_bytes[$];
	out_item_t censored_q[$];
	int        shown;

	function automatic logic alpha(input byte_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic byte_t lower(input byte_t c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	task automatic emit_oldest();
		int k;
		step_bytes.push_back(window[0]);
		prev_out = window[0];
		text_start = 1'b0;
		for (k = 0; k < DEPTH - 1; k++)
			window[k] = window[k + 1];
		held--;
	endtask

	// one input byte: decide the window head as far as the pattern length allows
	task automatic censor_byte(input byte_t b, input logic last);
		int n;
		int j;
		logic hit;
		logic whole;
		out_item_t item;
		n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
		if (held < DEPTH) begin
			window[held] = b;
			held++;
		end
		while (held > 0 && (last || held > n)) begin
			if (skip > 0) begin
				// bytes of an occurrence already decided
				emit_oldest();
				skip--;
			end else begin
				hit = (n > 0) && (held >= n);
				for (j = 0; j < n; j++)
					if (hit && lower(window[j]) != lower(pat_bytes[8*j +: 8]))
						hit = 1'b0;
				if (hit) begin
					whole = (text_start || !alpha(prev_out)) &&
						(held == n || !alpha(window[n]));
					if (whole)
						for (j = 0; j < n; j++)
							window[j] = repl_char;
					skip = n;
				end else begin
					emit_oldest();
				end
			end
		end
		for (j = 0; j < step_bytes.size(); j++) begin
			item.data = step_bytes[j];
			item.last = last && (j == step_bytes.size() - 1);
			censored_q.push_back(item);
		end
		step_bytes.delete();
		if (last) begin
			held = 0;
			skip = 0;
			prev_out = 8'h00;
			text_start = 1'b1;
		end
	endtask

	task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
		fail_count++;
		if (shown < SHOW_MAX) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			shown++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pat_bytes = '0;
			pat_len = '0;
			repl_char = REPL_RESET;
			held = 0;
			skip = 0;
			prev_out = 8'h00;
			text_start = 1'b1;
			fail_count = 0;
			shown = 0;
			owed_beats <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PATTERN_BYTES:    pat_bytes = cfg_data;
					REG_PATTERN_LEN:      pat_len = cfg_data[LEN_W-1:0];
					REG_REPLACEMENT_CHAR: repl_char = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				censor_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (censored_q.size() == 0) begin
					fail_count++;
					if (shown < SHOW_MAX) begin
						$display("%0t: output beat with nothing due, expected none, got %h last %b",
							$time, m_axis_tdata, m_axis_tlast);
						shown++;
					end
				end else begin
					want = censored_q.pop_front();
					if (want.data !== m_axis_tdata)
						report("out_byte", want.data, m_axis_tdata);
					if (want.last !== m_axis_tlast)
						report("out_last", 8'(want.last), 8'(m_axis_tlast));
				end
			end
			owed_beats <= censored_q.size();
		end
	end

endmodule

// File: bench/tb.sv
// testbench top for the whole-word pattern censor: clock, reset, config writes,
// text stimulus with random stalls on both streams, watchdog and verdict
// depends on wwpc_pkg, whole_word_pattern_censor and censor_checker
module tb;
	import wwpc_pkg::*;

	localparam int RANDOM_ITEMS  = 220;
	localparam int CALM_TAIL     = 40;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_LIMIT    = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;  // in_byte
	logic                 s_axis_tlast;  // in_last
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;  // out_byte
	logic                 m_axis_tlast;  // out_last
	int                   fail_count;
	int                   owed_beats;

	logic [PAT_W-1:0] cur_pat;
	int               cur_len;
	int               items;
	bit               steady;
	bit               hold_out;
	byte_t            text_q[$];
	int               quiet = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	whole_word_pattern_censor dut (.*);

	censor_checker chk (.*);

	function automatic byte_t rand_letter();
		byte_t c;
		c = byte_t'($urandom_range("a", "z"));
		if ($urandom_range(0, 1))
			c = c - 8'd32;
		return c;
	endfunction

	function automatic byte_t case_mix(input byte_t c);
		if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
			return c ^ 8'h20;
		return c;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PATTERN_BYTES)
			cur_pat = data;
		else if (idx == REG_PATTERN_LEN)
			cur_len = int'(data[LEN_W-1:0]);
	endtask

	task automatic apply_settings(input logic [PAT_W-1:0] pat, input int len, input int repl);
		cfg_write(REG_PATTERN_BYTES, pat);
		cfg_write(REG_PATTERN_LEN, PAT_W'(len));
		cfg_write(REG_REPLACEMENT_CHAR, PAT_W'(repl));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_settings();
		logic [PAT_W-1:0] pat;
		int len;
		int pick;
		int j;
		if ($urandom_range(0, 9) < 7) begin
			for (j = 0; j < 8; j++)
				pat[8*j +: 8] = rand_letter();
		end else begin
			pat = {$urandom, $urandom};
		end
		pick = $urandom_range(0, 19);
		if (pick < 2)
			len = 0;
		else if (pick < 4)
			len = 8;
		else if (pick == 4)
			len = $urandom_range(9, 15);
		else
			len = $urandom_range(1, 5);
		apply_settings(pat, len, $urandom_range(0, 255));
	endtask

	// block is idle once every due beat is out and the window has had time to drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (owed_beats != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	// words built around the current pattern, mostly well formed
	task automatic make_text(input int target);
		int eff;
		int kind;
		int side;
		int cut;
		int j;
		text_q.delete();
		eff = (cur_len > 8) ? 8 : cur_len;
		while (text_q.size() < target) begin
			kind = $urandom_range(0, 9);
			side = $urandom_range(0, 1);
			if (kind <= 3 || kind == 7) begin
				if (kind == 7 && side)
					text_q.push_back(rand_letter());
				for (j = 0; j < eff; j++)
					text_q.push_back(case_mix(cur_pat[8*j +: 8]));
				if (kind == 7 && !side)
					text_q.push_back(rand_letter());
			end else if (kind == 4) begin
				cut = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
				for (j = 0; j < cut; j++)
					text_q.push_back(case_mix(cur_pat[8*j +: 8]));
			end else if (kind <= 6) begin
				repeat ($urandom_range(1, 6)) text_q.push_back(rand_letter());
			end else if (kind == 8) begin
				text_q.push_back(byte_t'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 5))
				0, 1: text_q.push_back(" ");
				2:    text_q.push_back(",");
				3:    text_q.push_back(8'h00);
				4:    text_q.push_back(byte_t'($urandom_range(0, 255)));
				default: ;
			endcase
		end
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++) begin
			if (!steady && $urandom_range(0, 4) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= text_q[i];
			s_axis_tlast <= (i == text_q.size() - 1);
			do @(posedge clk); while (!s_axis_tready);
			items++;
		end
	endtask

	initial begin
		m_axis_tready = 1'b0;
		repeat (10) @(posedge clk);
		forever begin
			if (hold_out) begin
				// long stall so the window and output queue fill up
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (!steady && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int random_base;
		int phase;
		int texts;
		int t;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		items = 0;
		steady = 1'b0;
		hold_out = 1'b0;
		cur_pat = '0;
		cur_len = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero length, every byte passes
		text_q.delete();
		text_q.push_back(8'h00);
		text_q.push_back(8'hff);
		push_str("Az");
		send_text();
		settle();

		// whole word at start and end, embedded occurrence left alone
		apply_settings(64'h0000_0000_0074_6163, 3, 'h00);
		text_q.delete();
		push_str("CAT,cats cAt");
		send_text();
		settle();

		// zero bytes in pattern and text, occurrences do not overlap
		apply_settings(64'h0, 2, 'hff);
		text_q.delete();
		repeat (3) text_q.push_back(8'h00);
		text_q.push_back("a");
		send_text();
		settle();

		// length above the window saturates, all-ones pattern
		apply_settings({PAT_W{1'b1}}, 15, 'h5a);
		text_q.delete();
		repeat (9) text_q.push_back(8'hff);
		send_text();
		settle();

		random_base = items;
		for (phase = 0; items - random_base < RANDOM_ITEMS; phase++) begin
			steady = (phase % 5 == 3) || (items - random_base >= RANDOM_ITEMS - CALM_TAIL);
			random_settings();
			texts = $urandom_range(1, 3);
			for (t = 0; t < texts; t++) begin
				if (phase == 2 && t == 0) begin
					hold_out = 1'b1;
					make_text(48);
				end else begin
					make_text($urandom_range(1, 24));
				end
				send_text();
			end
			settle();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
